FILE: src/kpsd_pkg.sv
// Shared constants, types and the key map for the keypad scan and debounce block.
// No dependencies; imported by every module under src.
package kpsd_pkg;

    localparam int NUM_COLS = 3;
    localparam int NUM_ROWS = 4;
    localparam int COL_W    = 2;
    localparam int ROW_W    = 4;
    localparam int HIT_W    = 2;
    localparam int CNT_W    = 8;
    localparam int CHAR_W   = 7;

    localparam logic [CNT_W-1:0] THRESH_RESET = 8'd20;
    localparam logic [COL_W-1:0] LAST_COL     = COL_W'(NUM_COLS - 1);

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row_sense;
    } t_in_word;

    function automatic logic [CHAR_W-1:0] key_at(logic [COL_W-1:0] col,
                                                  logic [HIT_W-1:0] row);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        case ({col, row})
            4'b00_00: ch = 7'h33;
            4'b00_01: ch = 7'h36;
            4'b00_10: ch = 7'h39;
            4'b00_11: ch = 7'h23;
            4'b01_00: ch = 7'h32;
            4'b01_01: ch = 7'h35;
            4'b01_10: ch = 7'h38;
            4'b01_11: ch = 7'h30;
            4'b10_00: ch = 7'h31;
            4'b10_01: ch = 7'h34;
            4'b10_10: ch = 7'h37;
            4'b10_11: ch = 7'h2A;
            default:  ch = '0;
        endcase
        return ch;
    endfunction

endpackage

FILE: src/kpsd_in_reg.sv
// Input register stage: captures one row sense word per accepted handshake.
// Depends on kpsd_pkg.
module kpsd_in_reg
    import kpsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ROW_W-1:0] i_row_sense,
    input  logic             i_take,
    output t_in_word         o_word
);

    logic             r_valid;
    logic [ROW_W-1:0] r_row;

    assign o_ready          = !r_valid || i_take;
    assign o_word.valid     = r_valid;
    assign o_word.row_sense = r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_row <= i_row_sense;
        end
    end

endmodule

FILE: src/kpsd_scan.sv
// Scan and debounce engine: per-column press counters, column pointer, threshold
// register and the result register. Depends on kpsd_pkg.
module kpsd_scan
    import kpsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  t_in_word          i_word,
    output logic              o_take,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_key_valid,
    output logic [CHAR_W-1:0] o_key_char,
    output logic [COL_W-1:0]  o_next_column
);

    logic [CNT_W-1:0]  r_thresh;
    logic [COL_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_cnt [NUM_COLS];
    logic              r_out_valid;
    logic              r_key_valid;
    logic [CHAR_W-1:0] r_key_char;
    logic [COL_W-1:0]  r_next_col;

    logic              found;
    logic [HIT_W-1:0]  hit;
    logic [CNT_W-1:0]  n_cnt;
    logic [COL_W-1:0]  n_col;
    logic              n_key_valid;
    logic [CHAR_W-1:0] n_key_char;
    logic              out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_take   = i_word.valid && out_free;

    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int r = NUM_ROWS - 1; r >= 0; r--) begin
            if (i_word.row_sense[r]) begin
                found = 1'b1;
                hit   = HIT_W'(r);
            end
        end
    end

    assign n_cnt       = found ? r_cnt[r_col] + CNT_W'(1) : '0;
    assign n_key_valid = found && (n_cnt >= r_thresh);
    assign n_key_char  = n_key_valid ? key_at(r_col, hit) : '0;
    assign n_col       = (r_col == LAST_COL) ? '0 : r_col + COL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            for (int c = 0; c < NUM_COLS; c++) begin
                r_cnt[c] <= '0;
            end
        end else if (o_take) begin
            r_col        <= n_col;
            r_cnt[r_col] <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_key_valid <= n_key_valid;
            r_key_char  <= n_key_char;
            r_next_col  <= n_col;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_key_valid   = r_key_valid;
    assign o_key_char    = r_key_char;
    assign o_next_column = r_next_col;

endmodule

FILE: src/keypad_scan_debounce_core.sv
// Keypad scan and debounce core: 3-column by 4-row matrix, one word per column scan.
// An accepted word passes through the input register, then the result register, to result valid.
// Throughput: one word per cycle unless the output stalls; a counter update is a single step.
// Reset (synchronous, active low): column 0, all press counts 0, threshold 20, pipe empty.
// Depends on kpsd_pkg, kpsd_in_reg and kpsd_scan.
module keypad_scan_debounce_core
    import kpsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ROW_W-1:0]  i_row_sense,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_key_valid,
    output logic [CHAR_W-1:0] o_key_char,
    output logic [COL_W-1:0]  o_next_column
);

    t_in_word in_word;
    logic     take;

    kpsd_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_row_sense (i_row_sense),
        .i_take      (take),
        .o_word      (in_word)
    );

    kpsd_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_word        (in_word),
        .o_take        (take),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_key_valid   (o_key_valid),
        .o_key_char    (o_key_char),
        .o_next_column (o_next_column)
    );

    a_char_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_key_valid) |-> (o_key_char == '0))
        else $error("key_char nonzero without key_valid");

    a_char_nonzero_when_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_valid) |-> (o_key_char != '0))
        else $error("reported key has zero code");

    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_next_column <= LAST_COL))
        else $error("next_column out of range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while output side can drain");

endmodule

FILE: tb/keypad_scan_debounce_checker.sv
// Checker for the keypad scan and debounce core: tracks the threshold, column and
// per-column press counts, predicts each result word and compares it with the output.
// Depends on kpsd_pkg for widths.
module keypad_scan_debounce_checker
    import kpsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [ROW_W-1:0]  i_row_sense,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_key_valid,
    input  logic [CHAR_W-1:0] i_key_char,
    input  logic [COL_W-1:0]  i_next_column,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              key_valid;
        logic [CHAR_W-1:0] key_char;
        logic [COL_W-1:0]  next_column;
    } t_scan_result;

    byte key_map [NUM_COLS][NUM_ROWS] = '{
        '{"3", "6", "9", "#"},
        '{"2", "5", "8", "0"},
        '{"1", "4", "7", "*"}
    };

    logic [CNT_W-1:0] hold_thresh;
    logic [COL_W-1:0] scan_col;
    logic [CNT_W-1:0] press_cnt [NUM_COLS];
    t_scan_result     expected_scans [$];
    int               mismatches;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic t_scan_result debounce_scan(input logic [ROW_W-1:0] rows);
        t_scan_result res;
        logic         found;
        int           hit;
        found = 1'b0;
        hit   = 0;
        res   = '0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (rows[r]) begin
                found = 1'b1;
                hit   = r;
                break;
            end
        end
        if (!found) begin
            press_cnt[scan_col] = '0;
        end else begin
            press_cnt[scan_col] = press_cnt[scan_col] + 1'b1;
            if (press_cnt[scan_col] >= hold_thresh) begin
                res.key_valid = 1'b1;
                res.key_char  = key_map[scan_col][hit][CHAR_W-1:0];
            end
        end
        scan_col = (scan_col == COL_W'(NUM_COLS - 1)) ? '0 : scan_col + 1'b1;
        res.next_column = scan_col;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_scan_result got;
        t_scan_result want;
        if (!i_rst_n) begin
            hold_thresh = 8'd20;
            scan_col    = '0;
            for (int c = 0; c < NUM_COLS; c++) press_cnt[c] = '0;
            expected_scans.delete();
        end else begin
            if (i_cfg_we) hold_thresh = i_cfg_data;
            if (i_in_valid && i_in_ready) expected_scans.push_back(debounce_scan(i_row_sense));
            if (i_out_valid && i_out_ready) begin
                got = '{i_key_valid, i_key_char, i_next_column};
                if (expected_scans.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word valid=%0d char=%h col=%0d",
                                 $realtime, got.key_valid, got.key_char,
                                 got.next_column);
                end else begin
                    want = expected_scans.pop_front();
                    if (got.key_valid !== want.key_valid || got.key_char !== want.key_char
                        || got.next_column !== want.next_column) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch expected valid=%0d char=%h col=%0d,",
                                      " got valid=%0d char=%h col=%0d"},
                                     $realtime, want.key_valid, want.key_char,
                                     want.next_column, got.key_valid, got.key_char,
                                     got.next_column);
                    end
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_scans.size();
    end

endmodule

FILE: tb/keypad_scan_debounce_core_tb.sv
// Top of the keypad scan and debounce testbench: clock, reset, directed and random
// row words under changing idle patterns, threshold writes and the verdict.
// Depends on kpsd_pkg, keypad_scan_debounce_core and keypad_scan_debounce_checker.
module keypad_scan_debounce_core_tb;
    import kpsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]  i_cfg_data  = '0;
    logic              i_valid     = 1'b0;
    logic [ROW_W-1:0]  i_row_sense = '0;
    logic              i_ready     = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_key_valid;
    logic [CHAR_W-1:0] o_key_char;
    logic [COL_W-1:0]  o_next_column;
    int                errors;
    int                pending;
    int                words_sent  = 0;
    t_idle_mode        idle_mode   = IDLE_NONE;

    keypad_scan_debounce_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_row_sense   (i_row_sense),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_key_valid   (o_key_valid),
        .o_key_char    (o_key_char),
        .o_next_column (o_next_column)
    );

    keypad_scan_debounce_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_row_sense   (i_row_sense),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_key_valid   (o_key_valid),
        .i_key_char    (o_key_char),
        .i_next_column (o_next_column),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECV: i_ready <= $urandom_range(99) >= 70;
            IDLE_BOTH: i_ready <= $urandom_range(99) >= 26;
            default:   i_ready <= 1'b1;
        endcase
    end

    task automatic send_scan(input logic [ROW_W-1:0] rows);
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_SEND) ? 70 : (idle_mode == IDLE_BOTH) ? 26 : 0;
        while ($urandom_range(99) < pct) gap++;
        idle_mode <= t_idle_mode'((words_sent / 50) % 4);
        words_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_row_sense <= rows;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drain the pipe, then write the threshold while the block is idle
    task automatic set_threshold(input logic [CNT_W-1:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // held keys with random row content, short releases and some noise
    task automatic press_keys(input int n_words, input int min_run, input int max_run,
                              input int noise_pct);
        int               run_left;
        int               gap_left;
        logic [ROW_W-1:0] rows;
        run_left = 0;
        gap_left = 0;
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                rows = ROW_W'($urandom_range(15));
            end else if (run_left > 0) begin
                rows = ROW_W'($urandom_range(15, 1));
                run_left--;
            end else if (gap_left > 0) begin
                rows = '0;
                gap_left--;
            end else begin
                run_left = $urandom_range(max_run, min_run) - 1;
                gap_left = $urandom_range(3);
                rows     = ROW_W'($urandom_range(15, 1));
            end
            send_scan(rows);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        repeat (3) send_scan(4'b1111);
        set_threshold(8'd1);
        for (int j = 0; j < 12; j++) send_scan(ROW_W'(1) << (j / 3));
        send_scan(4'b0110);
        send_scan(4'b1100);
        send_scan(4'b1010);
        send_scan(4'b0000);
        send_scan(4'b0101);
        set_threshold(8'd0);
        send_scan(4'b0000);
        send_scan(4'b1000);
        send_scan(4'b1111);

        set_threshold(8'd20);
        press_keys(150, 1, 90, 10);
        set_threshold(8'd255);
        press_keys(800, 800, 800, 0);
        set_threshold(CNT_W'($urandom_range(10, 2)));
        press_keys(100, 1, 40, 15);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
